@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define CHK_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/qrs_pkg.sv @@
// Shared widths, stage tag types and the output saturation function.
// No dependencies.
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 16;
  localparam int MAG_W     = 34;              // |b*b - 4ac| < 2^34
  localparam int ROOT_W    = 17 + FRAC_BITS;  // sqrt steps and root width
  localparam int REM_W     = ROOT_W + 2;
  localparam int NUM_W     = ROOT_W + 1;      // numerator magnitude, divider steps
  localparam int QS_W      = NUM_W + 1;       // signed numerator / quotient
  localparam int DEN_W     = COEF_W + 1;      // |2a|
  localparam int OUT_W     = 34;
  localparam int EXT_W     = (QS_W > OUT_W) ? QS_W : OUT_W;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic                     neg;
    logic                     deg;
  } qrs_sq_tag_t;

  typedef struct packed {
    logic cplx;
    logic deg;
    logic sign0;
    logic sign1;
  } qrs_div_tag_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [QS_W-1:0] q);
    logic signed [EXT_W-1:0] qe;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    qe = EXT_W'(q);
    hi = EXT_W'({1'b0, {(OUT_W-1){1'b1}}});
    lo = -hi - EXT_W'(1);
    if (qe > hi) return hi[OUT_W-1:0];
    else if (qe < lo) return lo[OUT_W-1:0];
    else return qe[OUT_W-1:0];
  endfunction
endpackage

@@ design/qrs_disc.sv @@
// Two-stage discriminant: products, then difference and magnitude.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_disc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [qrs_pkg::COEF_W-1:0] a,
  input  logic signed [qrs_pkg::COEF_W-1:0] b,
  input  logic signed [qrs_pkg::COEF_W-1:0] c,
  output logic                              out_vld,
  output logic [qrs_pkg::MAG_W-1:0]         mag,
  output qrs_pkg::qrs_sq_tag_t              tag
);
  logic                              vld1;
  logic signed [2*qrs_pkg::COEF_W-1:0] bb;
  logic signed [2*qrs_pkg::COEF_W-1:0] ac;
  logic signed [qrs_pkg::COEF_W-1:0] a1;
  logic signed [qrs_pkg::COEF_W-1:0] b1;
  logic signed [qrs_pkg::MAG_W:0]    d;

  assign d = (qrs_pkg::MAG_W+1)'(bb) - ((qrs_pkg::MAG_W+1)'(ac) <<< 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bb      <= b * b;
      ac      <= a * c;
      a1      <= a;
      b1      <= b;
      mag     <= d[qrs_pkg::MAG_W] ? qrs_pkg::MAG_W'(-d) : d[qrs_pkg::MAG_W-1:0];
      tag.a   <= a1;
      tag.b   <= b1;
      tag.neg <= d[qrs_pkg::MAG_W];
      tag.deg <= (a1 == '0);
    end
  end
endmodule

@@ design/qrs_sqrt.sv @@
// Pipelined fixed-point square root, one result bit per stage.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [qrs_pkg::MAG_W-1:0]  mag,
  input  qrs_pkg::qrs_sq_tag_t       in_tag,
  output logic                       out_vld,
  output logic [qrs_pkg::ROOT_W-1:0] root,
  output qrs_pkg::qrs_sq_tag_t       out_tag
);
  localparam int N = qrs_pkg::ROOT_W;

  logic                       vld [N+1];
  logic [qrs_pkg::MAG_W-1:0]  xs  [N+1];
  logic [qrs_pkg::ROOT_W-1:0] rs  [N+1];
  logic [qrs_pkg::REM_W-1:0]  rm  [N+1];
  qrs_pkg::qrs_sq_tag_t       tg  [N+1];

  assign vld[0] = in_vld;
  assign xs[0]  = mag;
  assign rs[0]  = '0;
  assign rm[0]  = '0;
  assign tg[0]  = in_tag;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [qrs_pkg::REM_W+1:0] rsh;
    logic [qrs_pkg::REM_W+1:0] trial;
    logic                      take;
    assign rsh   = {rm[k], xs[k][qrs_pkg::MAG_W-1 -: 2]};
    assign trial = {2'b00, rs[k], 2'b01};
    assign take  = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1] <= xs[k] << 2;
        rs[k+1] <= {rs[k][qrs_pkg::ROOT_W-2:0], take};
        rm[k+1] <= take ? qrs_pkg::REM_W'(rsh - trial) : rsh[qrs_pkg::REM_W-1:0];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign out_vld = vld[N];
  assign root    = rs[N];
  assign out_tag = tg[N];
endmodule

@@ design/qrs_div.sv @@
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage. Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [qrs_pkg::NUM_W-1:0] num0,
  input  logic [qrs_pkg::NUM_W-1:0] num1,
  input  logic [qrs_pkg::DEN_W-1:0] den,
  input  qrs_pkg::qrs_div_tag_t     in_tag,
  output logic                      out_vld,
  output logic [qrs_pkg::NUM_W-1:0] quo0,
  output logic [qrs_pkg::NUM_W-1:0] quo1,
  output qrs_pkg::qrs_div_tag_t     out_tag
);
  localparam int N = qrs_pkg::NUM_W;

  logic                      vld [N+1];
  logic [qrs_pkg::NUM_W-1:0] n0  [N+1];
  logic [qrs_pkg::NUM_W-1:0] n1  [N+1];
  logic [qrs_pkg::DEN_W-1:0] r0  [N+1];
  logic [qrs_pkg::DEN_W-1:0] r1  [N+1];
  logic [qrs_pkg::DEN_W-1:0] dv  [N+1];
  qrs_pkg::qrs_div_tag_t     tg  [N+1];

  assign vld[0] = in_vld;
  assign n0[0]  = num0;
  assign n1[0]  = num1;
  assign r0[0]  = '0;
  assign r1[0]  = '0;
  assign dv[0]  = den;
  assign tg[0]  = in_tag;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [qrs_pkg::DEN_W:0] s0;
    logic [qrs_pkg::DEN_W:0] s1;
    logic                    t0;
    logic                    t1;
    assign s0 = {r0[k], n0[k][qrs_pkg::NUM_W-1]};
    assign s1 = {r1[k], n1[k][qrs_pkg::NUM_W-1]};
    assign t0 = (s0 >= {1'b0, dv[k]});
    assign t1 = (s1 >= {1'b0, dv[k]});

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    // Quotient bits shift in where numerator bits leave.
    always_ff @(posedge clk) begin
      if (en) begin
        n0[k+1] <= {n0[k][qrs_pkg::NUM_W-2:0], t0};
        n1[k+1] <= {n1[k][qrs_pkg::NUM_W-2:0], t1};
        r0[k+1] <= t0 ? qrs_pkg::DEN_W'(s0 - {1'b0, dv[k]}) : s0[qrs_pkg::DEN_W-1:0];
        r1[k+1] <= t1 ? qrs_pkg::DEN_W'(s1 - {1'b0, dv[k]}) : s1[qrs_pkg::DEN_W-1:0];
        dv[k+1] <= dv[k];
        tg[k+1] <= tg[k];
      end
    end
  end

  assign out_vld = vld[N];
  assign quo0    = n0[N];
  assign quo1    = n1[N];
  assign out_tag = tg[N];
endmodule

@@ design/quadratic_root_solver_unit.sv @@
// Quadratic root solver: discriminant stages, bit-per-stage square root, numerator
// stage, bit-per-stage divider and output register, in that order.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits at the output register.
// Reset (rst, synchronous): clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
module quadratic_root_solver_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qrs_pkg::OUT_W-1:0]  first_real,
  output logic signed [qrs_pkg::OUT_W-1:0]  second_real,
  output logic signed [qrs_pkg::OUT_W-1:0]  imag_part,
  output logic                              is_complex,
  output logic                              degenerate
);
  // Advance every stage together when the output slot is free or drains.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Discriminant stages.
  logic                       d_vld;
  logic [qrs_pkg::MAG_W-1:0]  d_mag;
  qrs_pkg::qrs_sq_tag_t       d_tag;

  qrs_disc u_disc (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(in_valid), .a(coef_a), .b(coef_b), .c(coef_c),
    .out_vld(d_vld), .mag(d_mag), .tag(d_tag)
  );

  // Square root of |D| scaled by 2^(2*FRAC_BITS).
  logic                       s_vld;
  logic [qrs_pkg::ROOT_W-1:0] s_root;
  qrs_pkg::qrs_sq_tag_t       s_tag;

  qrs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(d_vld), .mag(d_mag), .in_tag(d_tag),
    .out_vld(s_vld), .root(s_root), .out_tag(s_tag)
  );

  // Numerator stage: real roots divide -b*2^F +/- s; complex roots divide
  // -b*2^F for the real part and s for the imaginary part. Split each into
  // sign and magnitude for the unsigned divider.
  logic signed [qrs_pkg::QS_W-1:0] nbx;
  logic signed [qrs_pkg::QS_W-1:0] sx;
  logic signed [qrs_pkg::QS_W-1:0] sn0;
  logic signed [qrs_pkg::QS_W-1:0] sn1;

  assign nbx = -(qrs_pkg::QS_W'(s_tag.b) <<< qrs_pkg::FRAC_BITS);
  assign sx  = qrs_pkg::QS_W'({1'b0, s_root});
  assign sn0 = s_tag.neg ? nbx : nbx + sx;
  assign sn1 = s_tag.neg ? sx  : nbx - sx;

  logic                      n_vld;
  logic [qrs_pkg::NUM_W-1:0] n_num0;
  logic [qrs_pkg::NUM_W-1:0] n_num1;
  logic [qrs_pkg::DEN_W-1:0] n_den;
  qrs_pkg::qrs_div_tag_t     n_tag;
  logic                      a_neg;

  always_ff @(posedge clk) begin
    if (rst) n_vld <= 1'b0;
    else if (en) n_vld <= s_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_num0      <= sn0[qrs_pkg::QS_W-1] ? qrs_pkg::NUM_W'(-sn0) : sn0[qrs_pkg::NUM_W-1:0];
      n_num1      <= sn1[qrs_pkg::QS_W-1] ? qrs_pkg::NUM_W'(-sn1) : sn1[qrs_pkg::NUM_W-1:0];
      n_den       <= a_neg ? qrs_pkg::DEN_W'(-(qrs_pkg::DEN_W'(s_tag.a)) <<< 1)
                           : qrs_pkg::DEN_W'(qrs_pkg::DEN_W'(s_tag.a) <<< 1);
      n_tag.cplx  <= s_tag.neg;
      n_tag.deg   <= s_tag.deg;
      n_tag.sign0 <= sn0[qrs_pkg::QS_W-1] ^ a_neg;
      n_tag.sign1 <= sn1[qrs_pkg::QS_W-1] ^ a_neg;
    end
  end
  assign a_neg = s_tag.a[qrs_pkg::COEF_W-1];

  // Division by |2a|, truncating toward zero.
  logic                      q_vld;
  logic [qrs_pkg::NUM_W-1:0] q0;
  logic [qrs_pkg::NUM_W-1:0] q1;
  qrs_pkg::qrs_div_tag_t     q_tag;

  qrs_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_vld(n_vld), .num0(n_num0), .num1(n_num1), .den(n_den), .in_tag(n_tag),
    .out_vld(q_vld), .quo0(q0), .quo1(q1), .out_tag(q_tag)
  );

  // Output register: restore signs, saturate, route lanes, zero degenerate.
  logic signed [qrs_pkg::QS_W-1:0] qs0;
  logic signed [qrs_pkg::QS_W-1:0] qs1;
  logic signed [qrs_pkg::OUT_W-1:0] v0;
  logic signed [qrs_pkg::OUT_W-1:0] v1;

  assign qs0 = q_tag.sign0 ? -qrs_pkg::QS_W'(q0) : qrs_pkg::QS_W'(q0);
  assign qs1 = q_tag.sign1 ? -qrs_pkg::QS_W'(q1) : qrs_pkg::QS_W'(q1);
  assign v0  = qrs_pkg::sat_out(qs0);
  assign v1  = qrs_pkg::sat_out(qs1);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= q_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= q_tag.deg;
      if (q_tag.deg) begin
        first_real  <= '0;
        second_real <= '0;
        imag_part   <= '0;
        is_complex  <= 1'b0;
      end else begin
        first_real  <= v0;
        second_real <= q_tag.cplx ? v0 : v1;
        imag_part   <= q_tag.cplx ? v1 : '0;
        is_complex  <= q_tag.cplx;
      end
    end
  end
endmodule

@@ design/qrs_checker.sv @@
// Port-level checks on the solver's result channel, bound to the top level.
// Depends on qrs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module qrs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [qrs_pkg::OUT_W-1:0] first_real,
  input logic signed [qrs_pkg::OUT_W-1:0] second_real,
  input logic signed [qrs_pkg::OUT_W-1:0] imag_part,
  input logic                             is_complex,
  input logic                             degenerate
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(first_real))
  `CHK_NOW(a_deg_zero, clk, rst, out_valid && degenerate, first_real == '0 && second_real == '0 && imag_part == '0 && !is_complex)
  `CHK_NOW(a_real_noimag, clk, rst, out_valid && !is_complex, imag_part == '0)
  `CHK_NOW(a_conj_pair, clk, rst, out_valid && is_complex, first_real == second_real)
endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);
